### rtl/lcws_pkg.sv
// Shared constants, types and helpers for the load cell weight scaler.
// No dependencies; every other file imports this package.
package lcws_pkg;

  localparam int CODE_W    = 24;
  localparam int GAP_W     = 16;
  localparam int DIV10_W   = 21;
  localparam int DIGIT_W   = 6;
  localparam int BCD_N     = 5;
  localparam int CNT_W     = $clog2(CODE_W + 1);

  localparam logic [CODE_W-1:0]  SIGN_FLIP  = CODE_W'(24'h800000);
  localparam logic [CODE_W-1:0]  TARE_RESET = CODE_W'(10);
  localparam logic [GAP_W-1:0]   GAP_RESET  = GAP_W'(76);
  localparam logic [DIGIT_W-1:0] ASCII_ZERO = DIGIT_W'(8'h30);
  localparam logic [4:0]         TEN        = 5'd10;

  localparam logic FUNC_WEIGH = 1'b0;
  localparam logic FUNC_TARE  = 1'b1;

  // Step control shared by the serial units.
  typedef struct packed {
    logic start;
    logic step;
  } step_ctrl_t;

  typedef logic [3:0] bcd_t;

  function automatic logic [DIGIT_W-1:0] ascii_digit(input bcd_t d);
    return ASCII_ZERO + DIGIT_W'(d);
  endfunction

endpackage

### rtl/lcws_if.sv
// Valid/ready channel interfaces for the load cell weight scaler.
// Depends on lcws_pkg for field widths.
interface lcws_in_if import lcws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [CODE_W-1:0] raw_code;

  modport source (output valid, output func, output raw_code, input ready);
  modport sink   (input valid, input func, input raw_code, output ready);
endinterface

interface lcws_out_if import lcws_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  weight;
  logic [DIV10_W-1:0] weight_div_ten;
  logic [DIGIT_W-1:0] digit_ten_thousands;
  logic [DIGIT_W-1:0] digit_thousands;
  logic [DIGIT_W-1:0] digit_hundreds;
  logic [DIGIT_W-1:0] digit_tens;

  modport source (output valid, output weight, output weight_div_ten,
                  output digit_ten_thousands, output digit_thousands,
                  output digit_hundreds, output digit_tens, input ready);
  modport sink   (input valid, input weight, input weight_div_ten,
                  input digit_ten_thousands, input digit_thousands,
                  input digit_hundreds, input digit_tens, output ready);
endinterface

### rtl/lcws_divider.sv
// Bit-serial restoring divider: one quotient bit per step, MSB first.
// Depends on lcws_pkg.
module lcws_divider import lcws_pkg::*; (
  input  logic              clk,
  input  step_ctrl_t        ctrl,
  input  logic [CODE_W-1:0] dividend,
  input  logic [GAP_W-1:0]  divisor,
  output logic              qbit,
  output logic [CODE_W-1:0] quotient
);

  logic [CODE_W-1:0] dvd;
  logic [GAP_W-1:0]  rem;
  logic [GAP_W:0]    trial;
  logic [GAP_W:0]    diff;

  // A zero divisor always compares, giving an all-ones quotient.
  always_comb begin
    trial = {rem, dvd[CODE_W-1]};
    diff  = trial - {1'b0, divisor};
    qbit  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (ctrl.step) begin
      dvd <= {dvd[CODE_W-2:0], qbit};
      rem <= qbit ? diff[GAP_W-1:0] : trial[GAP_W-1:0];
    end
  end

  assign quotient = dvd;

endmodule

### rtl/lcws_digits.sv
// Serial decimal unit: divide by ten and double-dabble BCD, one bit a step.
// Depends on lcws_pkg.
module lcws_digits import lcws_pkg::*; (
  input  logic               clk,
  input  step_ctrl_t         ctrl,
  input  logic               bit_in,
  output logic [DIV10_W-1:0] div_ten,
  output bcd_t               bcd [BCD_N]
);

  logic [3:0] rem;
  logic [4:0] trial;
  logic [4:0] trial_sub;
  logic       ge;
  bcd_t       adj [BCD_N];
  bcd_t       bcd_reg [BCD_N];

  always_comb begin
    trial     = {rem, bit_in};
    trial_sub = trial - TEN;
    ge        = (trial >= TEN);
    for (int i = 0; i < BCD_N; i++) begin
      adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
    end
  end

  // Digits above ten-thousands are dropped; carries only move upward.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem     <= '0;
      div_ten <= '0;
      for (int i = 0; i < BCD_N; i++) bcd_reg[i] <= '0;
    end else if (ctrl.step) begin
      rem        <= ge ? trial_sub[3:0] : trial[3:0];
      div_ten    <= {div_ten[DIV10_W-2:0], ge};
      bcd_reg[0] <= {adj[0][2:0], bit_in};
      for (int i = 1; i < BCD_N; i++) bcd_reg[i] <= {adj[i][2:0], adj[i-1][3]};
    end
  end

  assign bcd = bcd_reg;

endmodule

### rtl/load_cell_weight_scaler.sv
// Load cell weight scaler, top level.
// Weigh request: 24 serial steps, then the result loads into the output register once it is free;
// the next request is accepted only after that load, and later while an older result still
// sits in the output register. Tare request: sets the tare offset, no result.
// Request rate is set by the 24-step bit-serial divider, which feeds the decimal unit in lockstep.
// Synchronous active-high rst: tare offset 10, gap value 76, no result pending.
module load_cell_weight_scaler import lcws_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [GAP_W-1:0] cfg_wdata,
  lcws_in_if.sink          in_ch,
  lcws_out_if.source       out_ch
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic [CODE_W-1:0]  tare;
  logic [GAP_W-1:0]   gap;
  logic               positive;

  // Output register; holds a finished result while the next request runs.
  logic               out_valid;
  logic [CODE_W-1:0]  weight;
  logic [DIV10_W-1:0] weight_div_ten;
  logic [DIGIT_W-1:0] digit_ten_thousands;
  logic [DIGIT_W-1:0] digit_thousands;
  logic [DIGIT_W-1:0] digit_hundreds;
  logic [DIGIT_W-1:0] digit_tens;

  logic [CODE_W-1:0]  code;
  logic [CODE_W-1:0]  diff;
  logic [GAP_W-1:0]   divisor;
  logic               accept;
  logic               out_free;
  step_ctrl_t         ctrl;
  logic               qbit;
  logic [CODE_W-1:0]  quotient;
  logic [DIV10_W-1:0] div_ten;
  bcd_t               bcd [BCD_N];

  // Flip the sign bit to get offset binary. A non-positive difference divides
  // zero by one, so it weighs zero even when the gap is zero.
  always_comb begin
    code       = in_ch.raw_code ^ SIGN_FLIP;
    diff       = (code > tare) ? code - tare : '0;
    divisor    = positive ? gap : GAP_W'(1);
    in_ch.ready = (state == ST_IDLE);
    accept     = in_ch.valid && in_ch.ready;
    ctrl.start = accept && (in_ch.func == FUNC_WEIGH);
    ctrl.step  = (state == ST_RUN);
    out_free   = !out_valid || out_ch.ready;
  end

  lcws_divider u_div (
    .clk      (clk),
    .ctrl     (ctrl),
    .dividend (diff),
    .divisor  (divisor),
    .qbit     (qbit),
    .quotient (quotient)
  );

  // Consumes each quotient bit in the same step it is decided.
  lcws_digits u_dig (
    .clk     (clk),
    .ctrl    (ctrl),
    .bit_in  (qbit),
    .div_ten (div_ten),
    .bcd     (bcd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      tare      <= TARE_RESET;
      gap       <= GAP_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) gap <= cfg_wdata;
      // A new result may load in the same cycle the old one is taken.
      if ((state == ST_DONE) && out_free) out_valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_ch.func == FUNC_TARE) begin
              tare <= code;
            end else begin
              state    <= ST_RUN;
              cnt      <= CNT_W'(CODE_W - 1);
              positive <= (code > tare);
            end
          end
        end
        ST_RUN: begin
          if (cnt == '0) state <= ST_DONE;
          else cnt <= cnt - 1'b1;
        end
        ST_DONE: begin
          // Wait here if the previous result has not been taken yet.
          if (out_free) begin
            weight              <= quotient;
            weight_div_ten      <= div_ten;
            digit_ten_thousands <= ascii_digit(bcd[4]);
            digit_thousands     <= ascii_digit(bcd[3]);
            digit_hundreds      <= ascii_digit(bcd[2]);
            digit_tens          <= ascii_digit(bcd[1]);
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid               = out_valid;
  assign out_ch.weight              = weight;
  assign out_ch.weight_div_ten      = weight_div_ten;
  assign out_ch.digit_ten_thousands = digit_ten_thousands;
  assign out_ch.digit_thousands     = digit_thousands;
  assign out_ch.digit_hundreds      = digit_hundreds;
  assign out_ch.digit_tens          = digit_tens;

endmodule

### sim/tb_top.sv
// Self-checking bench for load_cell_weight_scaler: tare/weigh requests with a scoreboard.
// Depends on rtl/lcws_pkg.sv, rtl/lcws_if.sv and rtl/load_cell_weight_scaler.sv.
// A queue-fed driver, a random-stall receiver and a clocked mirror of the tare/scale math.
module tb_top;
  import lcws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One request as the sender presents it.
  typedef struct {
    logic              func;
    logic [CODE_W-1:0] raw_code;
  } scale_req_t;

  // One weight result, all fields at the port widths.
  typedef struct {
    logic [CODE_W-1:0]  weight;
    logic [DIV10_W-1:0] weight_div_ten;
    logic [DIGIT_W-1:0] digit_ten_thousands;
    logic [DIGIT_W-1:0] digit_thousands;
    logic [DIGIT_W-1:0] digit_hundreds;
    logic [DIGIT_W-1:0] digit_tens;
  } weight_result_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [GAP_W-1:0] cfg_wdata;

  lcws_in_if  in_ch ();
  lcws_out_if out_ch ();

  load_cell_weight_scaler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  scale_req_t     pending_reqs[$];     // requests not yet offered to the block
  weight_result_t expected_weights[$]; // predicted results, oldest first

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned fail_count;

  // Mirror of the block's state, updated on accepted requests and register writes.
  logic [CODE_W-1:0] tare_mirror;
  logic [GAP_W-1:0]  gap_mirror;

  // Tare code as the stimulus generator expects it to be, used to aim weigh requests.
  logic [CODE_W-1:0] gen_tare;

  scale_req_t drv_req;

  // 10 ns clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [DIGIT_W-1:0] ascii_place(logic [CODE_W-1:0] w, int unsigned place);
    return ASCII_ZERO + DIGIT_W'((w / place) % 10);
  endfunction

  // Flip the sign bit to get the offset-binary code, subtract the tare, and scale.
  // A difference that is zero or negative weighs nothing; a zero gap saturates.
  function automatic weight_result_t predict_weight(logic [CODE_W-1:0] raw,
                                                    logic [CODE_W-1:0] tare,
                                                    logic [GAP_W-1:0]  gap);
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] w;
    weight_result_t    r;
    code = raw ^ SIGN_FLIP;
    w = '0;
    if (code > tare) begin
      if (gap == '0) w = '1;
      else w = (code - tare) / gap;
    end
    r.weight              = w;
    r.weight_div_ten      = DIV10_W'(w / 10);
    r.digit_ten_thousands = ascii_place(w, 10000);
    r.digit_thousands     = ascii_place(w, 1000);
    r.digit_hundreds      = ascii_place(w, 100);
    r.digit_tens          = ascii_place(w, 10);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers the next pending request once the current one is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_req = pending_reqs.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.func     <= drv_req.func;
        in_ch.raw_code <= drv_req.raw_code;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: tracks register writes and accepted requests, checks each result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    weight_result_t exp_r;
    if (rst) begin
      tare_mirror = TARE_RESET;
      gap_mirror  = GAP_RESET;
    end else begin
      if (cfg_we) gap_mirror = cfg_wdata;

      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.func == FUNC_TARE) begin
          // tare request: new offset, no result
          tare_mirror = in_ch.raw_code ^ SIGN_FLIP;
        end else begin
          expected_weights.push_back(predict_weight(in_ch.raw_code, tare_mirror, gap_mirror));
        end
      end

      if (out_ch.valid && out_ch.ready) begin
        if (expected_weights.size() == 0) begin
          $error("weight: unexpected result, got %0d", out_ch.weight);
          fail_count++;
        end else begin
          exp_r = expected_weights.pop_front();
          check_field("weight", exp_r.weight, out_ch.weight);
          check_field("weight_div_ten", exp_r.weight_div_ten, out_ch.weight_div_ten);
          check_field("digit_ten_thousands", exp_r.digit_ten_thousands,
                      out_ch.digit_ten_thousands);
          check_field("digit_thousands", exp_r.digit_thousands, out_ch.digit_thousands);
          check_field("digit_hundreds", exp_r.digit_hundreds, out_ch.digit_hundreds);
          check_field("digit_tens", exp_r.digit_tens, out_ch.digit_tens);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_tare(logic [CODE_W-1:0] raw);
    scale_req_t r;
    r.func     = FUNC_TARE;
    r.raw_code = raw;
    pending_reqs.push_back(r);
    gen_tare = raw ^ SIGN_FLIP;
  endtask

  task automatic push_weigh(logic [CODE_W-1:0] raw);
    scale_req_t r;
    r.func     = FUNC_WEIGH;
    r.raw_code = raw;
    pending_reqs.push_back(r);
  endtask

  // Weigh request whose offset-binary code is a given code.
  task automatic push_weigh_code(logic [CODE_W-1:0] code);
    push_weigh(code ^ SIGN_FLIP);
  endtask

  // Sender holds off until every request is taken and every result is back,
  // then keeps waiting in case a tare is still being absorbed.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_weights.size() != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_gap(logic [GAP_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Random traffic, mostly aimed around the current tare so the weights span
  // every digit position; some raw noise and some non-positive differences.
  task automatic fill_random(int unsigned n, logic [GAP_W-1:0] gap);
    longint unsigned   span;
    int unsigned       gap_eff;
    int unsigned       sel;
    logic [CODE_W-1:0] delta;
    gap_eff = (gap == 0) ? 1 : gap;
    span = longint'(gap_eff) * 100000;
    if (span > 24'hFFFFFF) span = 24'hFFFFFF;

    // extremes of the difference under this gap
    push_tare(SIGN_FLIP);
    push_weigh_code('1);
    push_weigh_code(CODE_W'(1));
    push_weigh_code('0);

    for (int unsigned i = 4; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 15) begin
        push_tare(CODE_W'($urandom));
      end else if (sel < 85) begin
        case ($urandom_range(3))
          0: delta = CODE_W'($urandom_range(0, 3 * gap_eff));
          1: delta = CODE_W'($urandom_range(0, int'(span)));
          2: delta = -CODE_W'($urandom_range(0, 1000));
          default: delta = CODE_W'($urandom);
        endcase
        push_weigh_code(gen_tare + delta);
      end else begin
        push_weigh(CODE_W'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [GAP_W-1:0] phase_gap[6];

    // everything known from time zero
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_WEIGH;
    in_ch.raw_code = '0;
    out_ch.ready   = 1'b0;
    fail_count     = 0;
    gen_tare       = TARE_RESET;

    // sender mostly busy, receiver mostly stalled
    send_idle_pct = 6;
    recv_idle_pct = 85;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under reset state: gap 76, tare code 10.
    push_weigh(24'h000000);          // code mid-scale
    push_weigh(24'h7FFFFF);          // largest code
    push_weigh(24'h800000);          // code 0, below tare: weight 0
    push_weigh(24'h80000A);          // equal to tare: weight 0
    push_weigh(24'h80000B);          // one count over: rounds to 0
    push_weigh(24'h800056);          // exactly one gap over: weight 1
    push_weigh(24'hFFFFFF);
    push_tare(24'h800000);           // tare at code 0
    push_weigh(24'h800000);
    push_weigh(24'h800001);
    push_weigh(24'h7FFFFF);          // full-range difference
    push_tare(24'h7FFFFF);           // tare at the top code
    push_weigh(24'h7FFFFF);
    push_weigh(24'h000000);          // below a high tare: weight 0
    push_tare(24'h123456);           // back-to-back tares, last one wins
    push_tare(24'h800000);
    push_weigh_code(CODE_W'(76 * 12345));       // digits 1 2 3 4
    push_weigh_code(CODE_W'(76 * 99999));       // all nines
    push_weigh_code(CODE_W'(76 * 98760 + 75));  // just under the next unit
    push_weigh_code(CODE_W'(76 * 10000));       // carry into ten-thousands
    push_weigh_code(CODE_W'(76 * 9));
    wait_drained();

    // Register settings per phase: both extremes, the saturating zero gap,
    // mid values and finally the reset value again.
    phase_gap[0] = 16'd1;
    phase_gap[1] = 16'hFFFF;
    phase_gap[2] = 16'd0;
    phase_gap[3] = GAP_W'($urandom_range(2, 65534));
    phase_gap[4] = 16'd300;
    phase_gap[5] = GAP_RESET;

    for (int p = 0; p < 6; p++) begin
      // swap the stall pattern, then drop stalls entirely
      if (p == 2) begin
        send_idle_pct = 85;
        recv_idle_pct = 6;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_gap(phase_gap[p]);
      fill_random(205, phase_gap[p]);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: ends a run that hangs, reporting a failure.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
